// File: hw/rtl/iiea_pkg.sv
// iiea_pkg: shared types and constants for the insertable shift array
// used by iiea_ctrl, iiea_cell and indexed_insert_erase_array_core

package iiea_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int LIVE_W   = 5;
    localparam int OP_W     = 3;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ERASE   = 3'd3,
        OP_REVERSE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_FROM_LOWER,
        SEL_FROM_UPPER
    } cell_sel_t;

    typedef struct packed {
        logic               fault;
        logic               read_en;
        logic [IDX_W-1:0]   phys_idx;
        logic [COUNT_W-1:0] count;
    } ctl_t;

endpackage

// File: hw/rtl/iiea_cell.sv
// iiea_cell: one storage cell of the shift chain
// depends on iiea_pkg for word and select types

module iiea_cell
    import iiea_pkg::*;
(
    input  logic      clk,
    input  cell_sel_t sel,
    input  word_t     load_data,
    input  word_t     lower_word,
    input  word_t     upper_word,
    output word_t     word
);

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        case (sel)
            SEL_HOLD:       word_next = word_reg;
            SEL_LOAD:       word_next = load_data;
            SEL_FROM_LOWER: word_next = lower_word;
            SEL_FROM_UPPER: word_next = upper_word;
            default:        word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// File: hw/rtl/iiea_ctrl.sv
// iiea_ctrl: element count, direction flag and per-cell shift control
// depends on iiea_pkg for op codes, select codes and the control struct

module iiea_ctrl
    import iiea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [OP_W-1:0]      op,
    input  logic [POS_W-1:0]     position,
    output cell_sel_t            sel [CAPACITY],
    output ctl_t                 ctl
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rev_reg;
    logic               rev_next;

    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   q_full;
    logic [CMP_W-1:0]   ii;
    logic               bad;

    always_comb
    begin
        pos_ext    = CMP_W'(position);
        cnt_ext    = CMP_W'(count_reg);
        bad        = 1'b0;
        q_full     = pos_ext;
        count_next = count_reg;
        rev_next   = rev_reg;
        ii         = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel[i] = SEL_HOLD;
        end

        case (op_t'(op))
            OP_READ, OP_WRITE, OP_ERASE:
            begin
                bad = !(pos_ext < cnt_ext);
                if (rev_reg)
                begin
                    q_full = cnt_ext - pos_ext - CMP_W'(1);
                end
            end
            OP_INSERT:
            begin
                bad = (cnt_ext == CMP_W'(CAPACITY)) || (pos_ext > cnt_ext);
                if (rev_reg)
                begin
                    q_full = cnt_ext - pos_ext;
                end
            end
            default:
            begin
                bad = 1'b0;
            end
        endcase

        if (!bad)
        begin
            case (op_t'(op))
                OP_WRITE:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ii = CMP_W'(i);
                        if (ii == q_full)
                        begin
                            sel[i] = SEL_LOAD;
                        end
                    end
                end
                OP_INSERT:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ii = CMP_W'(i);
                        if (ii == q_full)
                        begin
                            sel[i] = SEL_LOAD;
                        end
                        else if (ii > q_full && ii <= cnt_ext)
                        begin
                            sel[i] = SEL_FROM_LOWER;
                        end
                    end
                    count_next = count_reg + COUNT_W'(1);
                end
                OP_ERASE:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ii = CMP_W'(i);
                        if (ii >= q_full && CMP_W'(ii + CMP_W'(1)) < cnt_ext)
                        begin
                            sel[i] = SEL_FROM_UPPER;
                        end
                    end
                    count_next = count_reg - COUNT_W'(1);
                end
                OP_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    rev_next = rev_reg;
                end
            endcase
        end

        if (!advance)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                sel[i] = SEL_HOLD;
            end
        end

        ctl.fault    = bad;
        ctl.read_en  = (op_t'(op) == OP_READ) && !bad;
        ctl.phys_idx = q_full[IDX_W-1:0];
        ctl.count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

// File: hw/rtl/indexed_insert_erase_array_core.sv
// indexed_insert_erase_array_core: ordered store of signed words with
// insert, erase, read, write and reverse; one result item per input item
// the result is registered and presented in the cycle after the item is accepted
// throughput: one item per cycle while in_stall is low, all cells shift together in that cycle
// reverse flips a direction flag instead of moving words
// reset clears the count, the direction flag and the output valid; words are not cleared

module indexed_insert_erase_array_core
    import iiea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [POS_W-1:0]         position,
    input  logic signed [WORD_W-1:0] data_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] read_data,
    output logic [LIVE_W-1:0]        live_count,
    output logic                     fault
);

    logic      advance;
    cell_sel_t sel [CAPACITY];
    ctl_t      ctl;
    word_t     words [CAPACITY];
    word_t     rd_word;

    logic               out_valid_reg;
    logic               out_valid_next;
    word_t              read_data_reg;
    logic [LIVE_W-1:0]  live_count_reg;
    logic               fault_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign advance  = in_valid && !in_stall;

    iiea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .op       (op),
        .position (position),
        .sel      (sel),
        .ctl      (ctl)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t lower_w;
        word_t upper_w;

        if (g == 0)
        begin : g_first
            assign lower_w = data_in;
        end
        else
        begin : g_mid_lo
            assign lower_w = words[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_w = data_in;
        end
        else
        begin : g_mid_hi
            assign upper_w = words[g+1];
        end

        iiea_cell u_cell (
            .clk        (clk),
            .sel        (sel[g]),
            .load_data  (data_in),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (words[g])
        );
    end

    assign rd_word        = ctl.read_en ? words[ctl.phys_idx] : '0;
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg  <= rd_word;
            live_count_reg <= LIVE_W'(ctl.count);
            fault_reg      <= ctl.fault;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign live_count = live_count_reg;
    assign fault      = fault_reg;

endmodule

// File: tb/iiea_checker.sv
`timescale 1ns / 100ps
// iiea_checker: watches both channels of indexed_insert_erase_array_core, predicts each result
// from its own copy of the word store and compares field by field; depends on iiea_pkg

module iiea_checker
    import iiea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [POS_W-1:0]         position,
    input  logic signed [WORD_W-1:0] data_in,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WORD_W-1:0] read_data,
    input  logic [LIVE_W-1:0]        live_count,
    input  logic                     fault,
    output int                       fail_count,
    output int                       pending,
    output int                       model_count,
    output int                       results_checked,
    output int                       refusals
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        word_t             rd;
        logic [LIVE_W-1:0] cnt;
        logic              flt;
    } outcome_t;

    word_t    words [CAPACITY];
    int       live;
    outcome_t outcome_q [$];
    outcome_t got;
    outcome_t want;

    function automatic outcome_t apply_op(input logic [OP_W-1:0] code,
                                          input logic [POS_W-1:0] pos,
                                          input word_t val);
        outcome_t res;
        int       p;
        word_t    t;
        res = '0;
        p = int'(pos);
        case (code)
            OP_READ:
                if (p < live)
                    res.rd = words[p];
                else
                    res.flt = 1'b1;
            OP_WRITE:
                if (p < live)
                    words[p] = val;
                else
                    res.flt = 1'b1;
            OP_INSERT:
                if (live >= CAPACITY || p > live)
                    res.flt = 1'b1;
                else
                begin
                    for (int i = live; i > p; i--)
                        words[i] = words[i-1];
                    words[p] = val;
                    live++;
                end
            OP_ERASE:
                if (p < live)
                begin
                    for (int i = p; i < live - 1; i++)
                        words[i] = words[i+1];
                    live--;
                end
                else
                    res.flt = 1'b1;
            OP_REVERSE:
                for (int i = 0; i < live / 2; i++)
                begin
                    t = words[i];
                    words[i] = words[live-1-i];
                    words[live-1-i] = t;
                end
            default: ;
        endcase
        res.cnt = LIVE_W'(live);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live = 0;
            for (int i = 0; i < CAPACITY; i++)
                words[i] = '0;
            outcome_q.delete();
            fail_count = 0;
            pending = 0;
            model_count = 0;
            results_checked = 0;
            refusals = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.rd  = read_data;
                got.cnt = live_count;
                got.flt = fault;
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no item pending: read_data %0d live_count %0d fault %0b",
                                 $realtime, got.rd, got.cnt, got.flt);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    results_checked++;
                    if (got.rd !== want.rd || got.cnt !== want.cnt || got.flt !== want.flt)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: result %0d: read_data exp %0d got %0d, live_count exp %0d got %0d, fault exp %0b got %0b",
                                     $realtime, results_checked, want.rd, got.rd,
                                     want.cnt, got.cnt, want.flt, got.flt);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_op(op, position, data_in);
                if (want.flt)
                    refusals++;
                outcome_q.push_back(want);
            end
            pending = outcome_q.size();
            model_count = live;
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus, handshake pacing and verdict for indexed_insert_erase_array_core
// depends on iiea_pkg, the core itself and iiea_checker

module tb_top
    import iiea_pkg::*;
();

    localparam int    CLK_PERIOD     = 8;
    localparam int    RESET_CYCLES   = 8;
    localparam int    RANDOM_ITEMS   = 500;
    localparam int    TAIL_ITEMS     = 60;
    localparam int    HOLD_AT_ITEM   = 150;
    localparam int    HOLD_CYCLES    = 40;
    localparam int    CYCLE_LIMIT    = 200000;
    localparam int    DRAIN_CYCLES   = 4;
    localparam int    FIRST_SPARE_OP = OP_REVERSE + 1;
    localparam int    LAST_OP_CODE   = (1 << OP_W) - 1;
    localparam int    LAST_POSITION  = (1 << POS_W) - 1;
    localparam word_t WORD_MAX       = 32'sh7fff_ffff;
    localparam word_t WORD_MIN       = 32'sh8000_0000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [WORD_W-1:0] data_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] read_data;
    logic [LIVE_W-1:0]        live_count;
    logic                     fault;

    int fail_count;
    int pending;
    int model_count;
    int results_checked;
    int refusals;

    int items_sent = 0;
    int peak_fill = 0;
    int cycles = 0;
    bit quiet_tail = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done = 1'b0;
    bit grow = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    indexed_insert_erase_array_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .position   (position),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .live_count (live_count),
        .fault      (fault)
    );

    iiea_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .position        (position),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .live_count      (live_count),
        .fault           (fault),
        .fail_count      (fail_count),
        .pending         (pending),
        .model_count     (model_count),
        .results_checked (results_checked),
        .refusals        (refusals)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // call right after a falling edge
    task automatic offer(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                         input word_t val);
        in_valid <= 1'b1;
        op       <= code;
        position <= pos;
        data_in  <= val;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_item(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                             input word_t val);
        @(negedge clk);
        if (model_count > peak_fill)
            peak_fill = model_count;
        offer(code, pos, val);
    endtask

    task automatic idle_gap();
        int n;
        if (!quiet_tail && !hold_active && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_random(input bit force_insert);
        int          cnt;
        int          r;
        int          ins_w;
        int          ers_w;
        int          pos;
        logic [OP_W-1:0] code;
        word_t       val;
        @(negedge clk);
        cnt = model_count;
        if (cnt > peak_fill)
            peak_fill = cnt;
        if (cnt == CAPACITY && $urandom_range(0, 2) == 0)
            grow = 1'b0;
        else if (cnt == 0)
            grow = 1'b1;
        else if ($urandom_range(0, 40) == 0)
            grow = ~grow;
        ins_w = grow ? 40 : 12;
        ers_w = grow ? 12 : 40;
        r = $urandom_range(0, 99);
        if (force_insert)
            code = OP_INSERT;
        else if (r < 3)
            code = OP_W'($urandom_range(FIRST_SPARE_OP, LAST_OP_CODE));
        else if (r < 9)
            code = OP_REVERSE;
        else if (r < 9 + ins_w)
            code = OP_INSERT;
        else if (r < 9 + ins_w + ers_w)
            code = OP_ERASE;
        else if (r % 2 == 0)
            code = OP_READ;
        else
            code = OP_WRITE;

        if (!force_insert && $urandom_range(0, 9) == 0)
            pos = $urandom_range(0, LAST_POSITION);
        else if (code == OP_INSERT)
            pos = $urandom_range(0, cnt);
        else if (cnt > 0)
            pos = $urandom_range(0, cnt - 1);
        else
            pos = $urandom_range(0, LAST_POSITION);

        case ($urandom_range(0, 11))
            0: val = WORD_MAX;
            1: val = WORD_MIN;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
        endcase
        offer(code, POS_W'(pos), val);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_active = 1'b1;
                out_stall <= 1'b1;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_active = 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        @(posedge rst_n);

        // empty store
        send_item(OP_READ, '0, '0);
        send_item(OP_ERASE, '0, '0);
        send_item(OP_REVERSE, '0, '0);
        for (int c = FIRST_SPARE_OP; c <= LAST_OP_CODE; c++)
            send_item(OP_W'(c), POS_W'(c), WORD_MAX);
        send_item(OP_INSERT, '0, WORD_MAX);
        idle_gap();
        send_item(OP_REVERSE, '0, '0);
        send_item(OP_INSERT, POS_W'(1), WORD_MIN);
        send_item(OP_INSERT, POS_W'(3), '1);
        send_item(OP_WRITE, '0, '1);
        send_item(OP_READ, POS_W'(1), '0);
        send_item(OP_READ, POS_W'(LAST_POSITION), '0);
        send_item(OP_REVERSE, '0, '0);
        // fill to capacity
        repeat (CAPACITY - 2)
        begin
            send_random(1'b1);
            idle_gap();
        end
        send_item(OP_INSERT, '0, WORD_MIN);
        send_item(OP_REVERSE, '0, '0);
        send_item(OP_READ, POS_W'(CAPACITY - 1), '0);
        send_item(OP_WRITE, POS_W'(CAPACITY), WORD_MAX);
        send_item(OP_ERASE, POS_W'(CAPACITY - 1), '0);
        send_item(OP_ERASE, '0, '0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k >= RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            send_random(1'b0);
            idle_gap();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d items over %0d cycles, %0d results checked, %0d refused",
                 items_sent, cycles, results_checked, refusals);
        $display("store filled up to %0d of %0d words, output held off once for %0d cycles",
                 peak_fill, CAPACITY, HOLD_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
